// File: src/sacache_pkg.sv
// Package for the set-associative write-back cache core.
// Holds geometry constants, action and result codes, and shared types.
// Depends on nothing.
package sacache_pkg;

  localparam int SETS            = 256;
  localparam int WAYS            = 8;
  localparam int WORDS_PER_BLOCK = 8;
  localparam int TAG_BITS        = 19;

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WORD_W = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
  localparam int OB     = $clog2(WORDS_PER_BLOCK);
  localparam int IB     = $clog2(SETS);
  localparam int TSHIFT = 2 + OB + IB;
  localparam int LRU_W  = WAY_W;
  localparam int LINES  = SETS * WAYS;
  localparam int LINE_W = $clog2(LINES) > 0 ? $clog2(LINES) : 1;
  localparam int DATA_W = $clog2(LINES * WORDS_PER_BLOCK) > 0 ?
                          $clog2(LINES * WORDS_PER_BLOCK) : 1;
  localparam int CNT_W  = $clog2(WORDS_PER_BLOCK + 1);
  localparam logic [15:0] PENALTY_RESET = 16'd50;

  localparam int META_W = TAG_BITS + 2 + LRU_W;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FILL  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_RESP  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic                valid;
    logic                dirty;
    logic [LRU_W-1:0]    lru;
  } meta_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOOK, ST_HIT, ST_WB_RD, ST_WB_OUT, ST_RQ_OUT,
    ST_WAIT, ST_FILL_WR, ST_FIN_RD, ST_RESP
  } state_t;

endpackage

// File: src/sacache_ram.sv
// Generic single-port synchronous RAM with registered read.
// Used for the tag/metadata store and the data store. No dependencies.
module sacache_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: src/set_assoc_writeback_cache_core.sv
// Top level of the set-associative write-back cache core.
// Uses sacache_pkg and sacache_ram (metadata store and data store).
//
// After reset the core clears all SETS*WAYS (2048) lines of the metadata
// store and accepts no transaction then. Each way of the addressed set is read
// once to find a hit or a victim, then read and written once more to update its
// LRU count, all through the single metadata port. A hit then passes through
// ST_HIT and ST_FIN_RD to ST_RESP, where its response is registered. On a miss
// a dirty victim is written back word by word (a data read in ST_WB_RD, then
// the output in ST_WB_OUT), and then one read request is issued per word; the
// output can stall both. Each fill word is written the cycle after it is
// accepted; after the last fill the core passes through ST_WAIT and ST_FIN_RD
// to ST_RESP, where the response is registered. While a miss is pending only
// fill transactions are acted upon. The single-port memories set this order.
module set_assoc_writeback_cache_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] address,
  input  logic [31:0] write_data,
  input  logic [31:0] fill_data,
  input  logic [31:0] issue_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [31:0] mem_address,
  output logic [31:0] mem_data,
  output logic [31:0] read_data,
  output logic [31:0] done_cycle,
  output logic        last
);
  localparam int WC_W = $clog2(sacache_pkg::WAYS + 1);

  logic [15:0] miss_penalty;
  assign pready = 1'b1;
  assign prdata = {16'd0, miss_penalty};
  always_ff @(posedge clk) begin
    if (rst) begin
      miss_penalty <= sacache_pkg::PENALTY_RESET;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      miss_penalty <= pwdata[15:0];
    end
  end

  sacache_pkg::state_t state, state_next;

  logic [sacache_pkg::LINE_W-1:0] m_addr;
  logic                           m_we;
  sacache_pkg::meta_t             m_wdata, m_rdata;
  logic [sacache_pkg::DATA_W-1:0] d_addr;
  logic                           d_we;
  logic [31:0]                    d_wdata, d_rdata;

  sacache_ram #(.WIDTH(sacache_pkg::META_W), .DEPTH(sacache_pkg::LINES),
                .AW(sacache_pkg::LINE_W)) u_meta (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata));
  sacache_ram #(.WIDTH(32), .DEPTH(sacache_pkg::LINES * sacache_pkg::WORDS_PER_BLOCK),
                .AW(sacache_pkg::DATA_W)) u_data (
    .clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata));

  // Request registers.
  logic [1:0]  r_act;
  logic [31:0] r_wdata, r_cyc, r_fdata;
  logic [sacache_pkg::SET_W-1:0]    r_set;
  logic [sacache_pkg::WORD_W-1:0]   r_word;
  logic [sacache_pkg::TAG_BITS-1:0] r_tag;
  logic [sacache_pkg::TAG_BITS-1:0] old_tag;
  logic                             miss_pending;
  logic [sacache_pkg::CNT_W-1:0]    fill_count;

  // Way scan: phase 0 reads every way (find hit/victim), phase 1 rewrites LRU and the chosen line's flags.
  logic [WC_W-1:0]              scan;
  logic                         phase;
  logic                         hit_found;
  logic                         hit_now;
  logic [sacache_pkg::WAY_W-1:0] hit_way, victim, way;
  logic                         inv_found;
  logic [sacache_pkg::LRU_W-1:0] least;
  logic                         vic_dirty;
  logic [sacache_pkg::LINE_W-1:0] clr;
  logic [sacache_pkg::CNT_W-1:0]  cnt;
  logic                           rd_pend;
  logic                           was_hit;

  logic [1:0]  o_kind;
  logic [31:0] o_addr, o_mdata, o_rdata, o_done;
  logic        o_last, o_valid, o_load;

  assign kind = o_kind;
  assign mem_address = o_addr;
  assign mem_data = o_mdata;
  assign read_data = o_rdata;
  assign done_cycle = o_done;
  assign last = o_last;
  assign out_valid = o_valid;

  logic in_fire, out_free, start_req, start_fill;
  assign out_free = !o_valid || out_ready;
  assign in_ready = (state == sacache_pkg::ST_IDLE);
  assign in_fire = in_valid && in_ready;
  assign start_req = in_fire && !miss_pending &&
                     (action == sacache_pkg::ACT_READ || action == sacache_pkg::ACT_WRITE);
  assign start_fill = in_fire && miss_pending && action == sacache_pkg::ACT_FILL;
  assign hit_now = rd_pend && m_rdata.valid && (m_rdata.tag == r_tag);

  logic [sacache_pkg::SET_W-1:0]    in_set;
  logic [sacache_pkg::WORD_W-1:0]   in_word;
  logic [sacache_pkg::TAG_BITS-1:0] in_tag;
  always_comb begin
    in_word = sacache_pkg::WORD_W'((address >> 2) % sacache_pkg::WORDS_PER_BLOCK);
    in_set  = sacache_pkg::SET_W'((address >> (2 + sacache_pkg::OB)) % sacache_pkg::SETS);
    in_tag  = sacache_pkg::TAG_BITS'(address >> sacache_pkg::TSHIFT);
  end

  logic [sacache_pkg::WAY_W-1:0] cur_way, line_way;
  assign cur_way = sacache_pkg::WAY_W'(scan);
  assign line_way = was_hit ? hit_way : victim;

  function automatic logic [sacache_pkg::LINE_W-1:0] line_of(
      input logic [sacache_pkg::SET_W-1:0] s, input logic [sacache_pkg::WAY_W-1:0] w);
    line_of = sacache_pkg::LINE_W'(32'(s) * sacache_pkg::WAYS + 32'(w));
  endfunction

  function automatic logic [sacache_pkg::DATA_W-1:0] dat_of(
      input logic [sacache_pkg::LINE_W-1:0] l, input logic [sacache_pkg::WORD_W-1:0] w);
    dat_of = sacache_pkg::DATA_W'(32'(l) * sacache_pkg::WORDS_PER_BLOCK + 32'(w));
  endfunction

  function automatic logic [31:0] base_of(input logic [sacache_pkg::TAG_BITS-1:0] t,
                                          input logic [sacache_pkg::SET_W-1:0] s);
    base_of = (32'(t) << sacache_pkg::TSHIFT) | (32'(s) << (2 + sacache_pkg::OB));
  endfunction

  logic [sacache_pkg::LINE_W-1:0] line_sel;
  assign line_sel = line_of(r_set, line_way);

  always_comb begin
    state_next = state;
    m_we = 1'b0;
    m_addr = line_of(r_set, cur_way);
    m_wdata = m_rdata;
    d_we = 1'b0;
    d_addr = dat_of(line_sel, r_word);
    d_wdata = r_wdata;
    o_load = 1'b0;
    case (state)
      sacache_pkg::ST_CLEAR: begin
        m_we = 1'b1;
        m_addr = clr;
        m_wdata = '0;
        if (clr == sacache_pkg::LINE_W'(sacache_pkg::LINES - 1)) begin
          state_next = sacache_pkg::ST_IDLE;
        end
      end
      sacache_pkg::ST_IDLE: begin
        if (start_fill) begin
          state_next = sacache_pkg::ST_FILL_WR;
        end else if (start_req) begin
          state_next = sacache_pkg::ST_LOOK;
        end
      end
      sacache_pkg::ST_LOOK: begin
        // Phase 0: issue reads for ways 0..WAYS-1, examine each way's data in the next cycle.
        // Phase 1: read each way again, then write back its updated LRU (and the chosen line's flags).
        if (phase && rd_pend) begin
          m_we = 1'b1;
          m_addr = line_of(r_set, way);
          m_wdata = m_rdata;
          if (way == line_way) begin
            m_wdata.lru = sacache_pkg::LRU_W'(sacache_pkg::WAYS - 1);
            if (!was_hit) begin
              m_wdata.tag = r_tag;
              m_wdata.valid = 1'b1;
              m_wdata.dirty = 1'b0;
            end
            if (was_hit && r_act == sacache_pkg::ACT_WRITE) begin
              m_wdata.dirty = 1'b1;
            end
          end else if (m_rdata.lru != '0) begin
            m_wdata.lru = m_rdata.lru - 1'b1;
          end
        end
        if (phase && !rd_pend && scan == WC_W'(sacache_pkg::WAYS)) begin
          state_next = was_hit ? sacache_pkg::ST_HIT :
                       (vic_dirty ? sacache_pkg::ST_WB_RD : sacache_pkg::ST_RQ_OUT);
        end
      end
      sacache_pkg::ST_HIT: begin
        d_addr = dat_of(line_sel, r_word);
        d_we = (r_act == sacache_pkg::ACT_WRITE);
        state_next = sacache_pkg::ST_FIN_RD;
      end
      sacache_pkg::ST_WB_RD: begin
        d_addr = dat_of(line_sel, sacache_pkg::WORD_W'(cnt));
        if (out_free) begin
          state_next = sacache_pkg::ST_WB_OUT;
        end
      end
      sacache_pkg::ST_WB_OUT: begin
        d_addr = dat_of(line_sel, sacache_pkg::WORD_W'(cnt));
        if (out_free) begin
          o_load = 1'b1;
          state_next = (cnt == sacache_pkg::CNT_W'(sacache_pkg::WORDS_PER_BLOCK - 1)) ?
                       sacache_pkg::ST_RQ_OUT : sacache_pkg::ST_WB_RD;
        end
      end
      sacache_pkg::ST_RQ_OUT: begin
        if (out_free) begin
          o_load = 1'b1;
          if (cnt == sacache_pkg::CNT_W'(sacache_pkg::WORDS_PER_BLOCK - 1)) begin
            state_next = sacache_pkg::ST_IDLE;
          end
        end
      end
      sacache_pkg::ST_FILL_WR: begin
        d_we = 1'b1;
        d_addr = dat_of(line_sel, sacache_pkg::WORD_W'(fill_count));
        d_wdata = r_fdata;
        if (fill_count == sacache_pkg::CNT_W'(sacache_pkg::WORDS_PER_BLOCK - 1)) begin
          state_next = sacache_pkg::ST_WAIT;
        end else begin
          state_next = sacache_pkg::ST_IDLE;
        end
      end
      sacache_pkg::ST_WAIT: begin
        // Pending store after the last fill; its dirty mark is written in ST_FIN_RD.
        d_we = (r_act == sacache_pkg::ACT_WRITE);
        d_addr = dat_of(line_sel, r_word);
        m_addr = line_sel;
        state_next = sacache_pkg::ST_FIN_RD;
      end
      sacache_pkg::ST_FIN_RD: begin
        d_addr = dat_of(line_sel, r_word);
        m_addr = line_sel;
        if (!was_hit && r_act == sacache_pkg::ACT_WRITE) begin
          m_we = 1'b1;
          m_wdata = m_rdata;
          m_wdata.dirty = 1'b1;
        end
        state_next = sacache_pkg::ST_RESP;
      end
      sacache_pkg::ST_RESP: begin
        d_addr = dat_of(line_sel, r_word);
        if (out_free) begin
          o_load = 1'b1;
          state_next = sacache_pkg::ST_IDLE;
        end
      end
      default: state_next = sacache_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sacache_pkg::ST_CLEAR;
      clr <= '0;
      miss_pending <= 1'b0;
      fill_count <= '0;
      o_valid <= 1'b0;
      scan <= '0;
      phase <= 1'b0;
      rd_pend <= 1'b0;
      cnt <= '0;
    end else begin
      state <= state_next;
      o_valid <= o_load || (o_valid && !out_ready);
      case (state)
        sacache_pkg::ST_CLEAR: clr <= clr + 1'b1;
        sacache_pkg::ST_IDLE: begin
          if (start_fill) begin
            r_fdata <= fill_data;
          end
          if (start_req) begin
            r_act <= action;
            r_wdata <= write_data;
            r_cyc <= issue_time;
            r_set <= in_set;
            r_word <= in_word;
            r_tag <= in_tag;
            scan <= '0;
            phase <= 1'b0;
            rd_pend <= 1'b0;
            hit_found <= 1'b0;
            inv_found <= 1'b0;
            victim <= '0;
            least <= sacache_pkg::LRU_W'(sacache_pkg::WAYS - 1);
            cnt <= '0;
          end
        end
        sacache_pkg::ST_LOOK: begin
          if (!phase) begin
            if (rd_pend) begin
              if (hit_now && !hit_found) begin
                hit_found <= 1'b1;
                hit_way <= way;
              end
              if (!inv_found) begin
                if (!m_rdata.valid) begin
                  inv_found <= 1'b1;
                  victim <= way;
                end else if (m_rdata.lru < least) begin
                  least <= m_rdata.lru;
                  victim <= way;
                end
              end
            end
            if (scan != WC_W'(sacache_pkg::WAYS)) begin
              way <= cur_way;
              scan <= scan + 1'b1;
              rd_pend <= 1'b1;
            end else begin
              rd_pend <= 1'b0;
              phase <= 1'b1;
              scan <= '0;
              was_hit <= hit_found || hit_now;
            end
          end else begin
            if (way == line_way && rd_pend && !was_hit) begin
              old_tag <= m_rdata.tag;
              vic_dirty <= m_rdata.dirty;
            end
            if (rd_pend) begin
              rd_pend <= 1'b0;
            end else if (scan != WC_W'(sacache_pkg::WAYS)) begin
              way <= cur_way;
              scan <= scan + 1'b1;
              rd_pend <= 1'b1;
            end
          end
        end
        sacache_pkg::ST_WB_OUT: begin
          if (out_free) begin
            o_kind <= sacache_pkg::KIND_WRITE;
            o_addr <= base_of(old_tag, r_set) + 32'(cnt) * 32'd4;
            o_mdata <= d_rdata;
            o_rdata <= '0;
            o_done <= '0;
            o_last <= 1'b0;
            cnt <= (cnt == sacache_pkg::CNT_W'(sacache_pkg::WORDS_PER_BLOCK - 1)) ?
                   '0 : cnt + 1'b1;
          end
        end
        sacache_pkg::ST_RQ_OUT: begin
          if (out_free) begin
            o_kind <= sacache_pkg::KIND_READ;
            o_addr <= base_of(r_tag, r_set) + 32'(cnt) * 32'd4;
            o_mdata <= '0;
            o_rdata <= '0;
            o_done <= '0;
            o_last <= (cnt == sacache_pkg::CNT_W'(sacache_pkg::WORDS_PER_BLOCK - 1));
            cnt <= cnt + 1'b1;
            if (cnt == sacache_pkg::CNT_W'(sacache_pkg::WORDS_PER_BLOCK - 1)) begin
              miss_pending <= 1'b1;
              fill_count <= '0;
            end
          end
        end
        sacache_pkg::ST_FILL_WR: begin
          fill_count <= fill_count + 1'b1;
        end
        sacache_pkg::ST_RESP: begin
          if (out_free) begin
            o_kind <= sacache_pkg::KIND_RESP;
            o_addr <= '0;
            o_mdata <= '0;
            o_rdata <= d_rdata;
            o_done <= was_hit ? r_cyc : r_cyc + 32'(miss_penalty);
            o_last <= 1'b1;
            miss_pending <= 1'b0;
            fill_count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == sacache_pkg::ST_CLEAR |-> !in_ready)
    else $error("transaction accepted during clear");
  a_resp_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == sacache_pkg::KIND_RESP |-> last)
    else $error("cpu response without last");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= sacache_pkg::CNT_W'(sacache_pkg::WORDS_PER_BLOCK))
    else $error("fill count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mem_address))
    else $error("result dropped while stalled");
endmodule
